// ===== hdl/custom_register_window_with_copper_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the custom register window
// Clocked assertion shorthands shared by the checker.
// ----------------------------------------------------------------------------
`ifndef CUSTOM_REGISTER_WINDOW_WITH_COPPER_TOP_MACROS_SVH
`define CUSTOM_REGISTER_WINDOW_WITH_COPPER_TOP_MACROS_SVH

// Check a property on every rising edge, muted while reset is low.
`define CRWC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define CRWC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/crwc_pkg.sv =====
// ----------------------------------------------------------------------------
// crwc_pkg
// Types, register offsets and codes of the custom register window.
// ----------------------------------------------------------------------------
package crwc_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RD_FAULT = 2'd1,
    ST_WR_FAULT = 2'd2
  } status_e;

  // Window offsets (bit 0 always clear)
  localparam logic [8:0] OFS_DMA_READ  = 9'h002;
  localparam logic [8:0] OFS_SER_STAT  = 9'h018;
  localparam logic [8:0] OFS_IEN_READ  = 9'h01C;
  localparam logic [8:0] OFS_IRQ_READ  = 9'h01E;
  localparam logic [8:0] OFS_COP_CTRL  = 9'h02E;
  localparam logic [8:0] OFS_SER_DATA  = 9'h030;
  localparam logic [8:0] OFS_SER_PER   = 9'h032;
  localparam logic [8:0] OFS_LOC_HI    = 9'h080;
  localparam logic [8:0] OFS_LOC_LO    = 9'h082;
  localparam logic [8:0] OFS_COP_JUMP  = 9'h088;
  localparam logic [8:0] OFS_DMA_WRITE = 9'h096;
  localparam logic [8:0] OFS_IEN_WRITE = 9'h09A;
  localparam logic [8:0] OFS_IRQ_WRITE = 9'h09C;
  localparam logic [8:0] OFS_MASK      = 9'h1FE;

  localparam logic [15:0] SER_READY   = 16'h2000;
  localparam int unsigned BIT_COP_DMA = 7;
  localparam int unsigned BIT_DMA_ALL = 9;
  localparam int unsigned BIT_INT_ALL = 14;
  localparam int unsigned BIT_VBLANK  = 5;
  localparam int unsigned BIT_SET_CLR = 15;

  localparam logic [2:0]  IRQ_LEVEL_VBLANK = 3'd3;
  localparam logic [31:0] COP_STEP         = 32'd4;
  localparam logic [15:0] COP_END_W0       = 16'hFFFF;
  localparam logic [15:0] COP_END_W1       = 16'hFFFE;

  // Configuration register indexes and reset values
  localparam logic [1:0]  CFG_COP_INTERVAL = 2'd0;
  localparam logic [1:0]  CFG_VBL_INTERVAL = 2'd1;
  localparam logic [7:0]  COP_INTERVAL_RST = 8'd4;
  localparam logic [15:0] VBL_INTERVAL_RST = 16'd20000;

  typedef struct packed {
    logic        valid;
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic        valid;
    logic [8:0]  ofs;
    logic [15:0] data;
  } wr_req_t;

  // Register file view handed to the copper
  typedef struct packed {
    logic        dma_ok;
    logic        jump;
    logic [31:0] location;
  } cop_ctl_t;

endpackage

// ===== hdl/crwc_regs.sv =====
// ----------------------------------------------------------------------------
// crwc_regs
// Set/clear registers, copper location, bus decode and vblank timer.
// ----------------------------------------------------------------------------
module crwc_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  crwc_pkg::op_e      op_i,
  input  logic [8:0]         ofs_i,
  input  logic [15:0]        data_i,
  input  crwc_pkg::wr_req_t  cop_wr_i,
  input  crwc_pkg::cfg_wr_t  cfg_i,
  output logic [15:0]        read_data_o,
  output crwc_pkg::status_e  status_o,
  output logic               serial_valid_o,
  output logic [7:0]         serial_byte_o,
  output logic [2:0]         irq_level_o,
  output crwc_pkg::cop_ctl_t ctl_o
);

  logic [14:0] dma_q, dma_d;
  logic [14:0] ien_q, ien_d;
  logic [14:0] irq_q, irq_d;
  logic [31:0] loc_q, loc_d;
  logic [15:0] vbl_phase_q, vbl_phase_d;
  logic [15:0] vbl_int_q;
  logic [16:0] vbl_sum;
  logic        jump;
  crwc_pkg::wr_req_t wr;

  function automatic logic [14:0] set_clr(input logic [14:0] now, input logic [15:0] word);
    if (word[crwc_pkg::BIT_SET_CLR]) begin
      return now | word[14:0];
    end
    return now & ~word[14:0];
  endfunction

  always_comb begin
    if (op_i == crwc_pkg::OP_WRITE) begin
      wr.valid = 1'b1;
      wr.ofs   = ofs_i;
      wr.data  = data_i;
    end else begin
      wr = cop_wr_i;
    end
  end

  always_comb begin
    dma_d          = dma_q;
    ien_d          = ien_q;
    irq_d          = irq_q;
    loc_d          = loc_q;
    vbl_phase_d    = vbl_phase_q;
    vbl_sum        = {1'b0, vbl_phase_q} + 17'd1;
    read_data_o    = '0;
    status_o       = crwc_pkg::ST_OK;
    serial_valid_o = 1'b0;
    serial_byte_o  = '0;
    jump           = 1'b0;

    if (op_i == crwc_pkg::OP_READ) begin
      case (ofs_i)
        crwc_pkg::OFS_SER_STAT: read_data_o = crwc_pkg::SER_READY;
        crwc_pkg::OFS_DMA_READ: read_data_o = {1'b0, dma_q};
        crwc_pkg::OFS_IEN_READ: read_data_o = {1'b0, ien_q};
        crwc_pkg::OFS_IRQ_READ: read_data_o = {1'b0, irq_q};
        default:                status_o    = crwc_pkg::ST_RD_FAULT;
      endcase
    end

    if (wr.valid) begin
      case (wr.ofs)
        crwc_pkg::OFS_SER_DATA: begin
          serial_valid_o = 1'b1;
          serial_byte_o  = wr.data[7:0];
        end
        crwc_pkg::OFS_SER_PER:   ;
        crwc_pkg::OFS_COP_CTRL:  ;
        crwc_pkg::OFS_DMA_WRITE: dma_d = set_clr(dma_q, wr.data);
        crwc_pkg::OFS_LOC_HI:    loc_d = {wr.data, loc_q[15:0]};
        crwc_pkg::OFS_LOC_LO:    loc_d = {loc_q[31:16], wr.data};
        crwc_pkg::OFS_COP_JUMP:  jump = 1'b1;
        crwc_pkg::OFS_IEN_WRITE: ien_d = set_clr(ien_q, wr.data);
        crwc_pkg::OFS_IRQ_WRITE: irq_d = set_clr(irq_q, wr.data);
        default:                 status_o = crwc_pkg::ST_WR_FAULT;
      endcase
    end

    // Raise vblank after any copper write of this tick
    if (op_i == crwc_pkg::OP_TICK) begin
      if (vbl_phase_q == '0) begin
        irq_d[crwc_pkg::BIT_VBLANK] = 1'b1;
      end
      vbl_phase_d = (vbl_sum >= {1'b0, vbl_int_q}) ? '0 : vbl_sum[15:0];
    end

    irq_level_o = (ien_d[crwc_pkg::BIT_INT_ALL] && ien_d[crwc_pkg::BIT_VBLANK] &&
                   irq_d[crwc_pkg::BIT_VBLANK]) ? crwc_pkg::IRQ_LEVEL_VBLANK : 3'd0;
  end

  assign ctl_o.jump     = jump;
  assign ctl_o.dma_ok   = dma_q[crwc_pkg::BIT_COP_DMA] && dma_q[crwc_pkg::BIT_DMA_ALL];
  assign ctl_o.location = loc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dma_q       <= '0;
      ien_q       <= '0;
      irq_q       <= '0;
      loc_q       <= '0;
      vbl_phase_q <= '0;
      vbl_int_q   <= crwc_pkg::VBL_INTERVAL_RST;
    end else begin
      if (en_i) begin
        dma_q       <= dma_d;
        ien_q       <= ien_d;
        irq_q       <= irq_d;
        loc_q       <= loc_d;
        vbl_phase_q <= vbl_phase_d;
      end
      if (cfg_i.valid && cfg_i.index == crwc_pkg::CFG_VBL_INTERVAL) begin
        vbl_int_q <= cfg_i.data;
      end
    end
  end

endmodule

// ===== hdl/crwc_copper.sv =====
// ----------------------------------------------------------------------------
// crwc_copper
// Copper list stepper: program counter, beam counter, run flag and divider.
// ----------------------------------------------------------------------------
module crwc_copper (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               tick_i,
  input  logic [15:0]        w0_i,
  input  logic [15:0]        w1_i,
  input  crwc_pkg::cop_ctl_t ctl_i,
  input  crwc_pkg::cfg_wr_t  cfg_i,
  output crwc_pkg::wr_req_t  wr_o,
  output logic [31:0]        fetch_addr_o,
  output logic               active_o
);

  logic [31:0] pc_q, pc_d;
  logic [7:0]  beam_q, beam_d;
  logic        run_q, run_d;
  logic [7:0]  phase_q, phase_d;
  logic [7:0]  int_q;
  logic [8:0]  phase_sum;
  logic        step;

  assign step      = tick_i && (phase_q == '0) && run_q && ctl_i.dma_ok;
  assign phase_sum = {1'b0, phase_q} + 9'd1;

  always_comb begin
    pc_d     = pc_q;
    beam_d   = beam_q;
    run_d    = run_q;
    phase_d  = phase_q;
    wr_o.valid = 1'b0;
    wr_o.ofs   = w0_i[8:0] & crwc_pkg::OFS_MASK;
    wr_o.data  = w1_i;

    if (step) begin
      if (!w0_i[0]) begin
        // MOVE: advance and write like the processor would
        pc_d       = pc_q + crwc_pkg::COP_STEP;
        wr_o.valid = 1'b1;
      end else if (!w1_i[0]) begin
        if (w0_i == crwc_pkg::COP_END_W0 && w1_i == crwc_pkg::COP_END_W1) begin
          run_d = 1'b0;
        end else if (beam_q >= w0_i[15:8]) begin
          pc_d = pc_q + crwc_pkg::COP_STEP;
        end else begin
          beam_d = beam_q + 8'd1;
        end
      end else begin
        pc_d = pc_q + crwc_pkg::COP_STEP;
      end
    end

    // Jump wins over the step of the same item
    if (ctl_i.jump) begin
      pc_d   = ctl_i.location;
      beam_d = '0;
      run_d  = 1'b1;
    end

    if (tick_i) begin
      phase_d = (phase_sum >= {1'b0, int_q}) ? '0 : phase_sum[7:0];
    end
  end

  assign fetch_addr_o = pc_d;
  assign active_o     = run_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= '0;
      beam_q  <= '0;
      run_q   <= 1'b0;
      phase_q <= '0;
      int_q   <= crwc_pkg::COP_INTERVAL_RST;
    end else begin
      if (en_i) begin
        pc_q    <= pc_d;
        beam_q  <= beam_d;
        run_q   <= run_d;
        phase_q <= phase_d;
      end
      if (cfg_i.valid && cfg_i.index == crwc_pkg::CFG_COP_INTERVAL) begin
        int_q <= cfg_i.data[7:0];
      end
    end
  end

endmodule

// ===== hdl/custom_register_window_with_copper_top.sv =====
// ----------------------------------------------------------------------------
// custom_register_window_with_copper_top
// Custom register window with set/clear registers and a copper coprocessor.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle unless the output stalls; the input register
//   feeds one pass of decode and state update straight into the result
//   register; an accepted item passes both registers to become a result.
// Configuration writes are registered directly; cfg_ready_o is always high.
// Reset: asynchronous, active low; clears the state registers and both phase
//   counters, loads the intervals with 4 and 20000, and empties both stages.
module custom_register_window_with_copper_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [8:0] reg_offset, [24:9] write_data, [40:25] copper_first_word,
  // [56:41] copper_second_word, [63:57] zero
  input  logic [63:0] s_axis_tdata,
  // [1:0] operation
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] read_data, [17:16] status, [18] serial_valid, [26:19] serial_byte,
  // [29:27] irq_level, [61:30] copper_fetch_address, [62] copper_active,
  // [63] zero
  output logic [63:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic              in_valid_q;
  crwc_pkg::op_e     op_q;
  logic [8:0]        ofs_q;
  logic [15:0]       data_q, w0_q, w1_q;
  logic              out_valid_q;
  logic [63:0]       out_data_q, out_data_d;
  logic              advance;
  logic              take;

  crwc_pkg::cfg_wr_t  cfg;
  crwc_pkg::wr_req_t  cop_wr;
  crwc_pkg::cop_ctl_t ctl;
  crwc_pkg::status_e  status;
  logic [15:0]        read_data;
  logic               serial_valid;
  logic [7:0]         serial_byte;
  logic [2:0]         irq_level;
  logic [31:0]        fetch_addr;
  logic               active;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign take          = s_axis_tvalid && s_axis_tready;

  assign cfg_ready_o = 1'b1;
  assign cfg.valid   = cfg_valid_i;
  assign cfg.index   = cfg_index_i;
  assign cfg.data    = cfg_data_i;

  crwc_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (advance),
    .op_i           (op_q),
    .ofs_i          (ofs_q),
    .data_i         (data_q),
    .cop_wr_i       (cop_wr),
    .cfg_i          (cfg),
    .read_data_o    (read_data),
    .status_o       (status),
    .serial_valid_o (serial_valid),
    .serial_byte_o  (serial_byte),
    .irq_level_o    (irq_level),
    .ctl_o          (ctl)
  );

  crwc_copper u_copper (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance),
    .tick_i       (op_q == crwc_pkg::OP_TICK),
    .w0_i         (w0_q),
    .w1_i         (w1_q),
    .ctl_i        (ctl),
    .cfg_i        (cfg),
    .wr_o         (cop_wr),
    .fetch_addr_o (fetch_addr),
    .active_o     (active)
  );

  assign out_data_d = {1'b0, active, fetch_addr, irq_level, serial_byte,
                       serial_valid, status, read_data};

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: hold while stalled
  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q   <= crwc_pkg::op_e'(s_axis_tuser);
      ofs_q  <= s_axis_tdata[8:0] & crwc_pkg::OFS_MASK;
      data_q <= s_axis_tdata[24:9];
      w0_q   <= s_axis_tdata[40:25];
      w1_q   <= s_axis_tdata[56:41];
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== hdl/crwc_checker.sv =====
// ----------------------------------------------------------------------------
// crwc_checker
// Port-level checks of the custom register window, bound to the top level.
// ----------------------------------------------------------------------------
`include "custom_register_window_with_copper_top_macros.svh"

module crwc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  // A stalled result item holds
  `CRWC_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // No result item during reset
  `CRWC_ASSERT_ALWAYS(a_rst_idle, clk_i, !rst_ni |-> !m_axis_tvalid, "result valid in reset")

  // Interrupt level is either off or the vblank level
  `CRWC_ASSERT(a_irq_level, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tdata[29:27] == 3'd0 || m_axis_tdata[29:27] == 3'd3), "bad interrupt level")

  // Serial byte is zero when no byte goes out, and a fault emits no byte
  `CRWC_ASSERT(a_ser_quiet, clk_i, rst_ni, m_axis_tvalid && (!m_axis_tdata[18] || m_axis_tdata[17:16] != 2'd0) |-> m_axis_tdata[26:18] == 9'd0, "serial byte without write")

endmodule

bind custom_register_window_with_copper_top crwc_checker u_crwc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/custom_register_window_with_copper_top_tb.sv =====
// ----------------------------------------------------------------------------
// custom_register_window_with_copper_top_tb
// Self-checking bench for the custom register window and its copper.
// Bus reads, bus writes and instruction ticks go in on the input stream. An
// in-bench predictor tracks the set/clear registers, the copper and both
// phase counters, and every response is compared field by field in order.
// ----------------------------------------------------------------------------
module custom_register_window_with_copper_top_tb;

  localparam int unsigned SINK_HOLD_CYCLES = 80;
  localparam int unsigned STUCK_LIMIT      = 2000;
  localparam int unsigned ITEMS_PER_PHASE  = 115;
  localparam int unsigned RANDOM_PHASES    = 6;

  // Response layout of m_axis_tdata, highest bits first
  typedef struct packed {
    logic        spare;
    logic        active;
    logic [31:0] fetch_addr;
    logic [2:0]  irq_level;
    logic [7:0]  ser_byte;
    logic        ser_valid;
    logic [1:0]  status;
    logic [15:0] read_data;
  } resp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  // Predicted state of the window
  logic [14:0] pred_dma_ctl;
  logic [14:0] pred_int_ena;
  logic [14:0] pred_int_req;
  logic [31:0] pred_cop_loc;
  logic [31:0] pred_cop_pc;
  logic [7:0]  pred_beam;
  logic        pred_cop_run;
  int unsigned pred_cop_phase;
  int unsigned pred_vbl_phase;
  int unsigned pred_cop_ivl;
  int unsigned pred_vbl_ivl;
  resp_t       pred_resp;

  resp_t       pending_responses[$];
  int unsigned fail_count   = 0;
  int unsigned stuck_cycles = 0;
  bit          src_gaps_on   = 1'b0;
  bit          sink_gaps_on  = 1'b0;
  bit          sink_hold_req = 1'b0;

  custom_register_window_with_copper_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic [14:0] set_clear(logic [14:0] cur, logic [15:0] word);
    if (word[crwc_pkg::BIT_SET_CLR]) return cur | word[14:0];
    return cur & ~word[14:0];
  endfunction

  function automatic void window_write(logic [8:0] ofs, logic [15:0] word);
    case (ofs)
      crwc_pkg::OFS_SER_DATA: begin
        pred_resp.ser_valid = 1'b1;
        pred_resp.ser_byte  = word[7:0];
      end
      crwc_pkg::OFS_SER_PER, crwc_pkg::OFS_COP_CTRL: begin end
      crwc_pkg::OFS_LOC_HI:    pred_cop_loc[31:16] = word;
      crwc_pkg::OFS_LOC_LO:    pred_cop_loc[15:0]  = word;
      crwc_pkg::OFS_COP_JUMP: begin
        pred_cop_pc  = pred_cop_loc;
        pred_beam    = '0;
        pred_cop_run = 1'b1;
      end
      crwc_pkg::OFS_DMA_WRITE: pred_dma_ctl = set_clear(pred_dma_ctl, word);
      crwc_pkg::OFS_IEN_WRITE: pred_int_ena = set_clear(pred_int_ena, word);
      crwc_pkg::OFS_IRQ_WRITE: pred_int_req = set_clear(pred_int_req, word);
      default:                 pred_resp.status = crwc_pkg::ST_WR_FAULT;
    endcase
  endfunction

  function automatic void predict_copper(logic [15:0] w0, logic [15:0] w1);
    if (pred_cop_run && pred_dma_ctl[crwc_pkg::BIT_COP_DMA] &&
        pred_dma_ctl[crwc_pkg::BIT_DMA_ALL]) begin
      if (!w0[0]) begin
        // MOVE behaves exactly like a bus write
        pred_cop_pc = pred_cop_pc + crwc_pkg::COP_STEP;
        window_write(w0[8:0] & crwc_pkg::OFS_MASK, w1);
      end else if (!w1[0]) begin
        if (w0 == crwc_pkg::COP_END_W0 && w1 == crwc_pkg::COP_END_W1) pred_cop_run = 1'b0;
        else if (pred_beam >= w0[15:8]) pred_cop_pc = pred_cop_pc + crwc_pkg::COP_STEP;
        else pred_beam = pred_beam + 8'd1;
      end else begin
        pred_cop_pc = pred_cop_pc + crwc_pkg::COP_STEP;
      end
    end
  endfunction

  function automatic resp_t window_response(crwc_pkg::op_e op, logic [8:0] ofs_in,
                                            logic [15:0] wdata,
                                            logic [15:0] w0, logic [15:0] w1);
    logic [8:0] ofs;
    ofs       = ofs_in & crwc_pkg::OFS_MASK;
    pred_resp = '0;
    case (op)
      crwc_pkg::OP_READ: begin
        case (ofs)
          crwc_pkg::OFS_SER_STAT: pred_resp.read_data = crwc_pkg::SER_READY;
          crwc_pkg::OFS_DMA_READ: pred_resp.read_data = {1'b0, pred_dma_ctl};
          crwc_pkg::OFS_IEN_READ: pred_resp.read_data = {1'b0, pred_int_ena};
          crwc_pkg::OFS_IRQ_READ: pred_resp.read_data = {1'b0, pred_int_req};
          default:                pred_resp.status    = crwc_pkg::ST_RD_FAULT;
        endcase
      end
      crwc_pkg::OP_WRITE: window_write(ofs, wdata);
      crwc_pkg::OP_TICK: begin
        if (pred_cop_phase == 0) predict_copper(w0, w1);
        pred_cop_phase++;
        if (pred_cop_phase >= pred_cop_ivl) pred_cop_phase = 0;
        if (pred_vbl_phase == 0) pred_int_req[crwc_pkg::BIT_VBLANK] = 1'b1;
        pred_vbl_phase++;
        if (pred_vbl_phase >= pred_vbl_ivl) pred_vbl_phase = 0;
      end
      default: begin end
    endcase
    if (pred_int_ena[crwc_pkg::BIT_INT_ALL] && pred_int_ena[crwc_pkg::BIT_VBLANK] &&
        pred_int_req[crwc_pkg::BIT_VBLANK])
      pred_resp.irq_level = crwc_pkg::IRQ_LEVEL_VBLANK;
    pred_resp.fetch_addr = pred_cop_pc;
    pred_resp.active     = pred_cop_run;
    return pred_resp;
  endfunction

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic int unsigned gap_cycles();
    if ($urandom_range(0, 15) == 0) return $urandom_range(12, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [8:0] writable_ofs(int unsigned k);
    case (k)
      0:       return crwc_pkg::OFS_SER_DATA;
      1:       return crwc_pkg::OFS_SER_PER;
      2:       return crwc_pkg::OFS_COP_CTRL;
      3:       return crwc_pkg::OFS_LOC_HI;
      4:       return crwc_pkg::OFS_LOC_LO;
      5:       return crwc_pkg::OFS_COP_JUMP;
      6:       return crwc_pkg::OFS_DMA_WRITE;
      7:       return crwc_pkg::OFS_IEN_WRITE;
      default: return crwc_pkg::OFS_IRQ_WRITE;
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic send_item(crwc_pkg::op_e op, logic [8:0] ofs, logic [15:0] wdata,
                           logic [15:0] w0, logic [15:0] w1);
    if (src_gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap_cycles()) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, w1, w0, wdata, ofs};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_responses.push_back(window_response(op, ofs, wdata, w0, w1));
  endtask

  // Hold the input until every response is back, then let the pipe settle
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_intervals(logic [15:0] cop_word, logic [15:0] vbl_word);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= crwc_pkg::CFG_COP_INTERVAL;
    cfg_data_i  <= cop_word;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    pred_cop_ivl = 32'(cop_word[7:0]);
    cfg_index_i <= crwc_pkg::CFG_VBL_INTERVAL;
    cfg_data_i  <= vbl_word;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    pred_vbl_ivl = 32'(vbl_word);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random_item();
    int unsigned   pick;
    crwc_pkg::op_e op;
    logic [8:0]    ofs;
    logic [15:0]   wdata;
    logic [15:0]   w0;
    logic [15:0]   w1;
    pick  = $urandom_range(0, 99);
    ofs   = 9'($urandom_range(0, 511));
    wdata = 16'($urandom_range(0, 65535));
    w0    = 16'($urandom_range(0, 65535));
    w1    = 16'($urandom_range(0, 65535));
    if (pick < 4) begin
      // restart the copper list: enable copper and master DMA, load, jump
      send_item(crwc_pkg::OP_WRITE, crwc_pkg::OFS_DMA_WRITE, wdata | 16'h8280, w0, w1);
      if ($urandom_range(0, 1) != 0)
        send_item(crwc_pkg::OP_WRITE, crwc_pkg::OFS_IEN_WRITE, wdata | 16'hC020, w0, w1);
      send_item(crwc_pkg::OP_WRITE, crwc_pkg::OFS_LOC_HI,
                ($urandom_range(0, 3) == 0) ? 16'hFFFF : w0, w0, w1);
      send_item(crwc_pkg::OP_WRITE, crwc_pkg::OFS_LOC_LO, w1, w0, w1);
      send_item(crwc_pkg::OP_WRITE, crwc_pkg::OFS_COP_JUMP, wdata, w0, w1);
    end else begin
      if (pick < 9) begin
        op = crwc_pkg::OP_NONE;
      end else if (pick < 24) begin
        op = crwc_pkg::OP_READ;
        case ($urandom_range(0, 4))
          0:       ofs[8:1] = crwc_pkg::OFS_DMA_READ[8:1];
          1:       ofs[8:1] = crwc_pkg::OFS_SER_STAT[8:1];
          2:       ofs[8:1] = crwc_pkg::OFS_IEN_READ[8:1];
          3:       ofs[8:1] = crwc_pkg::OFS_IRQ_READ[8:1];
          default: begin end
        endcase
      end else if (pick < 58) begin
        op = crwc_pkg::OP_WRITE;
        if ($urandom_range(0, 4) != 0)
          ofs = writable_ofs($urandom_range(0, 8)) | {8'd0, ofs[0]};
        // keep copper DMA alive on most DMA writes
        if ((ofs & crwc_pkg::OFS_MASK) == crwc_pkg::OFS_DMA_WRITE) begin
          if (wdata[crwc_pkg::BIT_SET_CLR]) begin
            wdata[crwc_pkg::BIT_COP_DMA] = 1'b1;
            wdata[crwc_pkg::BIT_DMA_ALL] = 1'b1;
          end else if ($urandom_range(0, 3) != 0) begin
            wdata[crwc_pkg::BIT_COP_DMA] = 1'b0;
            wdata[crwc_pkg::BIT_DMA_ALL] = 1'b0;
          end
        end
      end else begin
        op   = crwc_pkg::OP_TICK;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          w0[0] = 1'b0;
          if ($urandom_range(0, 3) != 0) w0[8:0] = writable_ofs($urandom_range(0, 8));
        end else if (pick < 65) begin
          w0[0] = 1'b1;
          w1[0] = 1'b0;
          if ($urandom_range(0, 3) != 0) w0[15:8] = 8'($urandom_range(0, 6));
        end else if (pick < 72) begin
          w0 = crwc_pkg::COP_END_W0;
          w1 = crwc_pkg::COP_END_W1;
        end else if (pick < 85) begin
          w0[0] = 1'b1;
          w1[0] = 1'b1;
        end
      end
      send_item(op, ofs, wdata, w0, w1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_register_access();
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
    send_item(crwc_pkg::OP_READ,  crwc_pkg::OFS_SER_STAT, 16'h0000, 16'h0000, 16'h0000);
    // top of the window is unmodelled; bit 0 is dropped
    send_item(crwc_pkg::OP_READ,  9'h1FF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(crwc_pkg::OP_WRITE, 9'h1FF, 16'hFFFF, 16'h0000, 16'h0000);
    send_item(crwc_pkg::OP_READ,  9'h000, 16'h0000, 16'h0000, 16'h0000);
    send_item(crwc_pkg::OP_WRITE, crwc_pkg::OFS_SER_DATA, 16'hFFFF, 16'h0000, 16'h0000);
    send_item(crwc_pkg::OP_WRITE, crwc_pkg::OFS_SER_DATA | 9'h001, 16'hFF00,
              16'hFFFF, 16'hFFFF);
    send_item(crwc_pkg::OP_WRITE, crwc_pkg::OFS_SER_PER, 16'h0000, 16'h0000, 16'h0000);
    send_item(crwc_pkg::OP_WRITE, crwc_pkg::OFS_COP_CTRL, 16'hFFFF, 16'h0000, 16'h0000);
    send_item(crwc_pkg::OP_WRITE, crwc_pkg::OFS_DMA_WRITE, 16'hFFFF, 16'h0000, 16'h0000);
    send_item(crwc_pkg::OP_READ,  crwc_pkg::OFS_DMA_READ | 9'h001, 16'h0000,
              16'h0000, 16'h0000);
    send_item(crwc_pkg::OP_WRITE, crwc_pkg::OFS_DMA_WRITE, 16'h7FFF, 16'h0000, 16'h0000);
    send_item(crwc_pkg::OP_READ,  crwc_pkg::OFS_DMA_READ, 16'h0000, 16'h0000, 16'h0000);
    send_item(crwc_pkg::OP_WRITE, crwc_pkg::OFS_IEN_WRITE, 16'hC020, 16'h0000, 16'h0000);
    send_item(crwc_pkg::OP_WRITE, crwc_pkg::OFS_IRQ_WRITE, 16'h8020, 16'h0000, 16'h0000);
    send_item(crwc_pkg::OP_READ,  crwc_pkg::OFS_IRQ_READ, 16'h0000, 16'h0000, 16'h0000);
    send_item(crwc_pkg::OP_READ,  crwc_pkg::OFS_IEN_READ, 16'h0000, 16'h0000, 16'h0000);
    send_item(crwc_pkg::OP_WRITE, crwc_pkg::OFS_IRQ_WRITE, 16'h0020, 16'h0000, 16'h0000);
    send_item(crwc_pkg::OP_WRITE, crwc_pkg::OFS_LOC_HI, 16'hFFFF, 16'h0000, 16'h0000);
    send_item(crwc_pkg::OP_WRITE, crwc_pkg::OFS_LOC_LO, 16'hFFFC, 16'h0000, 16'h0000);
    send_item(crwc_pkg::OP_WRITE, crwc_pkg::OFS_COP_JUMP, 16'h0000, 16'h0000, 16'h0000);
    send_item(crwc_pkg::OP_NONE,  9'h1FF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    drain_results();
  endtask

  task automatic test_copper_program();
    // copper interval low byte zero steps on every tick
    set_intervals(16'h0100, 16'd1);
    send_item(crwc_pkg::OP_WRITE, crwc_pkg::OFS_DMA_WRITE, 16'h8280, 16'h0000, 16'h0000);
    send_item(crwc_pkg::OP_WRITE, crwc_pkg::OFS_COP_JUMP, 16'h0000, 16'h0000, 16'h0000);
    // MOVE to serial data; the counter wraps to zero
    send_item(crwc_pkg::OP_TICK, 9'h000, 16'h0000, 16'hFE30, 16'h1234);
    send_item(crwc_pkg::OP_TICK, 9'h000, 16'h0000, 16'h01FE, 16'hFFFF);
    send_item(crwc_pkg::OP_TICK, 9'h000, 16'h0000, 16'h009C, 16'h0020);
    // WAIT on beam position 2: two increments, then advance
    repeat (3) send_item(crwc_pkg::OP_TICK, 9'h000, 16'h0000, 16'h0201, 16'h0000);
    send_item(crwc_pkg::OP_TICK, 9'h000, 16'h0000, 16'h0001, 16'h0001);
    send_item(crwc_pkg::OP_TICK, 9'h000, 16'h0000, crwc_pkg::COP_END_W0,
              crwc_pkg::COP_END_W1);
    send_item(crwc_pkg::OP_TICK, 9'h000, 16'h0000, 16'h0030, 16'h00AA);
    send_item(crwc_pkg::OP_WRITE, crwc_pkg::OFS_COP_JUMP, 16'hFFFF, 16'h0000, 16'h0000);
    send_item(crwc_pkg::OP_WRITE, crwc_pkg::OFS_DMA_WRITE, 16'h0080, 16'h0000, 16'h0000);
    send_item(crwc_pkg::OP_TICK, 9'h000, 16'h0000, 16'h0030, 16'h0055);
    send_item(crwc_pkg::OP_WRITE, crwc_pkg::OFS_DMA_WRITE, 16'h8080, 16'h0000, 16'h0000);
    send_item(crwc_pkg::OP_WRITE, crwc_pkg::OFS_DMA_WRITE, 16'h0200, 16'h0000, 16'h0000);
    send_item(crwc_pkg::OP_TICK, 9'h000, 16'h0000, 16'h0030, 16'h0066);
    send_item(crwc_pkg::OP_WRITE, crwc_pkg::OFS_DMA_WRITE, 16'h8200, 16'h0000, 16'h0000);
    send_item(crwc_pkg::OP_TICK, 9'h000, 16'h0000, 16'h0088, 16'h0000);
    send_item(crwc_pkg::OP_TICK, 9'h000, 16'h0000, 16'h0030, 16'h00C3);
    drain_results();
  endtask

  task automatic test_backpressure();
    src_gaps_on   = 1'b0;
    sink_gaps_on  = 1'b0;
    sink_hold_req = 1'b1;
    repeat (24) send_random_item();
    drain_results();
  endtask

  task automatic test_random_traffic();
    logic [15:0] cop_word;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_results();
      case (ph)
        0: set_intervals(16'h00FF, 16'hFFFF);
        1: set_intervals(16'h0001, 16'h0000);
        2: set_intervals(16'h0002, 16'h0007);
        3: begin
          cop_word      = 16'($urandom_range(0, 65535));
          cop_word[7:0] = 8'($urandom_range(1, 6));
          set_intervals(cop_word, 16'($urandom_range(1, 300)));
        end
        4: set_intervals(16'hFF03, 16'd40);
        default: set_intervals({8'd0, crwc_pkg::COP_INTERVAL_RST},
                               crwc_pkg::VBL_INTERVAL_RST);
      endcase
      src_gaps_on  = (ph % 3 != 2);
      sink_gaps_on = (ph % 3 != 1);
      repeat (ITEMS_PER_PHASE) send_random_item();
    end
    drain_results();
  endtask

  // --------------------------------------------------------------------------
  // Response side: ready pattern, checking, watchdog
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
      end else if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        stall_left    = SINK_HOLD_CYCLES;
      end else if (sink_gaps_on && $urandom_range(0, 4) == 0) begin
        stall_left = gap_cycles();
      end
      m_axis_tready <= (stall_left == 0);
    end
  end

  always @(posedge clk_i) begin : check_results
    resp_t got;
    resp_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_responses.size() == 0) begin
        $error("response with none expected: %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_responses.pop_front();
        check_field("read_data", 32'(want.read_data), 32'(got.read_data));
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("serial_valid", 32'(want.ser_valid), 32'(got.ser_valid));
        check_field("serial_byte", 32'(want.ser_byte), 32'(got.ser_byte));
        check_field("irq_level", 32'(want.irq_level), 32'(got.irq_level));
        check_field("copper_fetch_address", want.fetch_addr, got.fetch_addr);
        check_field("copper_active", 32'(want.active), 32'(got.active));
        check_field("spare", 32'(want.spare), 32'(got.spare));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= crwc_pkg::OP_READ;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= crwc_pkg::CFG_COP_INTERVAL;
    cfg_data_i    <= '0;
    pred_dma_ctl   = '0;
    pred_int_ena   = '0;
    pred_int_req   = '0;
    pred_cop_loc   = '0;
    pred_cop_pc    = '0;
    pred_beam      = '0;
    pred_cop_run   = 1'b0;
    pred_cop_phase = 0;
    pred_vbl_phase = 0;
    pred_cop_ivl   = 32'(crwc_pkg::COP_INTERVAL_RST);
    pred_vbl_ivl   = 32'(crwc_pkg::VBL_INTERVAL_RST);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_access();
    test_copper_program();
    test_backpressure();
    test_random_traffic();

    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== custom_register_window_with_copper_top.f =====
+incdir+hdl
hdl/crwc_pkg.sv
hdl/crwc_regs.sv
hdl/crwc_copper.sv
hdl/custom_register_window_with_copper_top.sv
hdl/crwc_checker.sv
tb/custom_register_window_with_copper_top_tb.sv
